// File: design/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, widths and codes of the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int FRAC_BITS  = 8;
    localparam int LIMIT_W    = 31;
    localparam int ACC_W      = LIMIT_W + 1;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DER_W      = DATA_W + 2;
    localparam int PROD_P_W   = GAIN_W + ERR_W;
    localparam int PROD_I_W   = GAIN_W + ACC_W;
    localparam int PROD_D_W   = GAIN_W + DER_W;
    localparam int SUM_W      = PROD_I_W + 2;
    localparam int SHIFT_W    = SUM_W - FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    typedef enum logic {
        OP_STEP  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_TARGET  = 3'd3,
        CFG_LIMIT   = 3'd4,
        CFG_FLOOR   = 3'd5,
        CFG_CEILING = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [DATA_W-1:0] target;
        logic        [LIMIT_W-1:0] limit;
        logic signed [DATA_W-1:0] floor_val;
        logic signed [DATA_W-1:0] ceiling_val;
    } t_cfg;

    typedef struct packed {
        logic                    clear;
        logic signed [ERR_W-1:0] err;
        logic signed [ACC_W-1:0] integ;
        logic signed [DER_W-1:0] deriv;
    } t_err_stage;

    typedef struct packed {
        logic                       clear;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } t_prod_stage;

endpackage

// File: design/pidaw_in_if.sv
// ----------------------------------------------------------------------------
// pidaw_in_if
// Input item channel: operation and measurement.
// ----------------------------------------------------------------------------
interface pidaw_in_if
    import pidaw_pkg::*;
;
    logic                     valid;
    logic                     ready;
    t_op                      operation;
    logic signed [DATA_W-1:0] measurement;

    modport source (output valid, output operation, output measurement, input ready);
    modport sink   (input valid, input operation, input measurement, output ready);
endinterface

// File: design/pidaw_out_if.sv
// ----------------------------------------------------------------------------
// pidaw_out_if
// Result item channel: saturated drive value.
// ----------------------------------------------------------------------------
interface pidaw_out_if
    import pidaw_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// File: design/pidaw_err.sv
// ----------------------------------------------------------------------------
// pidaw_err
// Error, clamped integral and derivative; holds the controller state.
// ----------------------------------------------------------------------------
module pidaw_err
    import pidaw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_meas,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_err_stage               o_stage
);

    logic                      r_valid;
    t_err_stage                r_stage;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ERR_W-1:0]   r_last;
    logic                      accept;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [ACC_W:0]     raw_integ;
    logic signed [ACC_W:0]     lim_pos;
    logic signed [ACC_W:0]     lim_neg;
    logic signed [ACC_W-1:0]   n_integ;
    logic signed [DER_W-1:0]   n_deriv;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_err     = ERR_W'(i_cfg.target) - ERR_W'(i_meas);
        raw_integ = (ACC_W+1)'(r_acc) + (ACC_W+1)'(n_err);
        lim_pos   = $signed({2'b00, i_cfg.limit});
        lim_neg   = -lim_pos;
        if (raw_integ > lim_pos) begin
            n_integ = ACC_W'(lim_pos);
        end else if (raw_integ < lim_neg) begin
            n_integ = ACC_W'(lim_neg);
        end else begin
            n_integ = ACC_W'(raw_integ);
        end
        n_deriv = DER_W'(n_err) - DER_W'(r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_last  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                if (i_op == OP_CLEAR) begin
                    r_acc  <= '0;
                    r_last <= '0;
                end else begin
                    r_acc  <= n_integ;
                    r_last <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage.clear <= (i_op == OP_CLEAR);
            r_stage.err   <= n_err;
            r_stage.integ <= n_integ;
            r_stage.deriv <= n_deriv;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_CLEAR |=> r_acc == '0 && r_last == '0)
        else $error("state not cleared after clear item");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_acc) && $stable(r_last))
        else $error("state changed without an accepted item");

endmodule

// File: design/pidaw_mult.sv
// ----------------------------------------------------------------------------
// pidaw_mult
// Gain products of the proportional, integral and derivative terms.
// ----------------------------------------------------------------------------
module pidaw_mult
    import pidaw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_err_stage  i_stage,
    output logic        o_valid,
    input  logic        i_ready,
    output t_prod_stage o_stage
);

    logic        r_valid;
    t_prod_stage r_stage;
    logic        accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage.clear  <= i_stage.clear;
            r_stage.prod_p <= PROD_P_W'(i_cfg.gain_p) * PROD_P_W'(i_stage.err);
            r_stage.prod_i <= PROD_I_W'(i_cfg.gain_i) * PROD_I_W'(i_stage.integ);
            r_stage.prod_d <= PROD_D_W'(i_cfg.gain_d) * PROD_D_W'(i_stage.deriv);
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// File: design/pidaw_out.sv
// ----------------------------------------------------------------------------
// pidaw_out
// Term sum, fraction shift, ceiling and floor clamp, result register.
// ----------------------------------------------------------------------------
module pidaw_out
    import pidaw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_prod_stage              i_stage,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_drive
);

    logic                      r_valid;
    logic signed [DATA_W-1:0]  r_drive;
    logic                      accept;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SHIFT_W-1:0] scaled;
    logic signed [SHIFT_W-1:0] capped;
    logic signed [SHIFT_W-1:0] floored;
    logic signed [DATA_W-1:0]  n_drive;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        sum    = SUM_W'(i_stage.prod_p) + SUM_W'(i_stage.prod_i) + SUM_W'(i_stage.prod_d);
        scaled = SHIFT_W'(sum >>> FRAC_BITS);
        if (scaled > SHIFT_W'(i_cfg.ceiling_val)) begin
            capped = SHIFT_W'(i_cfg.ceiling_val);
        end else begin
            capped = scaled;
        end
        if (capped < SHIFT_W'(i_cfg.floor_val)) begin
            floored = SHIFT_W'(i_cfg.floor_val);
        end else begin
            floored = capped;
        end
        n_drive = i_stage.clear ? '0 : DATA_W'(floored);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_valid;
    assign o_drive = r_drive;

    a_clear_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_stage.clear |=> r_drive == '0)
        else $error("clear item produced nonzero drive");

endmodule

// File: design/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point PID controller with clamped integral and saturated output.
// ----------------------------------------------------------------------------
// channel   dir  fields                         handshake
// i_item    in   operation, measurement         valid / ready
// o_result  out  drive                          valid / ready
// i_cfg_*   in   we, idx, data (7 registers)    write on i_cfg_we
//
// one item per cycle sustained while o_result.ready holds; each accepted item passes
// the error/integral stage, multiply stage, sum and clamp into the result register
// integral and previous error update when the item is accepted, so items
// may follow back to back
// synchronous active-low reset clears state and loads register defaults
// each stage holds while the next is full; ready falls only when all are full
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
    import pidaw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pidaw_in_if.sink              i_item,
    pidaw_out_if.source           o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        err_valid;
    logic        err_ready;
    t_err_stage  err_stage;
    logic        prod_valid;
    logic        prod_ready;
    t_prod_stage prod_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= '0;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.target      <= '0;
            r_cfg.limit       <= '0;
            r_cfg.floor_val   <= {1'b1, {(DATA_W-1){1'b0}}};
            r_cfg.ceiling_val <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:  r_cfg.gain_p      <= GAIN_W'(i_cfg_data);
                CFG_GAIN_I:  r_cfg.gain_i      <= GAIN_W'(i_cfg_data);
                CFG_GAIN_D:  r_cfg.gain_d      <= GAIN_W'(i_cfg_data);
                CFG_TARGET:  r_cfg.target      <= DATA_W'(i_cfg_data);
                CFG_LIMIT:   r_cfg.limit       <= LIMIT_W'(i_cfg_data);
                CFG_FLOOR:   r_cfg.floor_val   <= DATA_W'(i_cfg_data);
                CFG_CEILING: r_cfg.ceiling_val <= DATA_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    pidaw_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_op    (i_item.operation),
        .i_meas  (i_item.measurement),
        .o_valid (err_valid),
        .i_ready (err_ready),
        .o_stage (err_stage)
    );

    pidaw_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (err_valid),
        .o_ready (err_ready),
        .i_stage (err_stage),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_stage (prod_stage)
    );

    pidaw_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_stage (prod_stage),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_drive (o_result.drive)
    );

endmodule

// File: test/pid_drive_checker.sv
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the item, result and register ports of the PID controller. It keeps
// its own copy of the gains, limits, integral and previous error, works out
// the drive value for every accepted item and compares it with the oldest
// result still awaited.
// ----------------------------------------------------------------------------
module pid_drive_checker
    import pidaw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pidaw_in_if                   i_item,
    pidaw_out_if                  i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg                     settings;
    logic signed [ACC_W-1:0]  acc_state;
    logic signed [ERR_W-1:0]  err_state;
    logic signed [DATA_W-1:0] expected_drive[$];
    int                       fail_count = 0;

    function automatic logic signed [DATA_W-1:0] next_drive(
        t_op op, logic signed [DATA_W-1:0] meas);
        longint err;
        longint integ;
        longint sum;
        longint drv;
        if (op == OP_CLEAR) begin
            acc_state = '0;
            err_state = '0;
            return '0;
        end
        err   = longint'($signed(settings.target)) - longint'(meas);
        integ = longint'(acc_state) + err;
        if (integ > longint'(settings.limit)) begin
            integ = longint'(settings.limit);
        end else if (integ < -longint'(settings.limit)) begin
            integ = -longint'(settings.limit);
        end
        sum = longint'($signed(settings.gain_p)) * err
            + longint'($signed(settings.gain_i)) * integ
            + longint'($signed(settings.gain_d)) * (err - longint'(err_state));
        acc_state = ACC_W'(integ);
        err_state = ERR_W'(err);
        drv = sum >>> FRAC_BITS;
        if (drv > longint'($signed(settings.ceiling_val))) begin
            drv = longint'($signed(settings.ceiling_val));
        end
        if (drv < longint'($signed(settings.floor_val))) begin
            drv = longint'($signed(settings.floor_val));
        end
        return DATA_W'(drv);
    endfunction

    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        if (!i_rst_n) begin
            settings             = '0;
            settings.floor_val   = 16'sh8000;
            settings.ceiling_val = 16'sh7fff;
            acc_state            = '0;
            err_state            = '0;
            expected_drive.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P:  settings.gain_p      = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:  settings.gain_i      = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:  settings.gain_d      = i_cfg_data[GAIN_W-1:0];
                    CFG_TARGET:  settings.target      = i_cfg_data[DATA_W-1:0];
                    CFG_LIMIT:   settings.limit       = i_cfg_data[LIMIT_W-1:0];
                    CFG_FLOOR:   settings.floor_val   = i_cfg_data[DATA_W-1:0];
                    CFG_CEILING: settings.ceiling_val = i_cfg_data[DATA_W-1:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_drive.size() == 0) begin
                    $error("drive: no item awaited, actual %0d", i_result.drive);
                    fail_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (i_result.drive !== want) begin
                        $error("drive: expected %0d, actual %0d", want, i_result.drive);
                        fail_count++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_drive.push_back(next_drive(i_item.operation, i_item.measurement));
            end
        end
        o_pending    <= expected_drive.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: test/pid_controller_antiwindup_tb.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_tb
// Drives the PID controller through directed corner items (field extremes,
// clear, floor above ceiling, zero and full integral limits) and then random
// phases, each under fresh register settings, with random gaps on both sides,
// a long result stall and a full drain. The checker predicts every drive value.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_tb
    import pidaw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending_drive;
    int                    check_failures;
    int                    tx_idle_pct = 18;
    int                    rx_idle_pct = 18;
    int                    rx_hold_left = 0;

    pidaw_in_if  item_ch ();
    pidaw_out_if result_ch ();

    pid_controller_antiwindup i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pid_drive_checker drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (check_failures),
        .o_pending    (pending_drive)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3, 4:    return DATA_W'(int'($urandom_range(0, 1023)) - 512);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_item(t_op op, logic [DATA_W-1:0] meas);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.measurement <= meas;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drive != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // upper bits above a 16-bit register are junk and must be dropped
    task automatic load_settings(t_cfg s);
        write_reg(CFG_UNUSED, 31'($urandom));
        write_reg(CFG_GAIN_P, {15'($urandom), s.gain_p});
        write_reg(CFG_GAIN_I, {15'($urandom), s.gain_i});
        write_reg(CFG_GAIN_D, {15'($urandom), s.gain_d});
        write_reg(CFG_TARGET, {15'($urandom), s.target});
        write_reg(CFG_LIMIT, s.limit);
        write_reg(CFG_FLOOR, {15'($urandom), s.floor_val});
        write_reg(CFG_CEILING, {15'($urandom), s.ceiling_val});
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(int n_items, int hold_at, int pause_at);
        t_cfg                     s;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic [DATA_W-1:0]        meas;
        int                       mode;
        int                       bias;
        s.gain_p = pick_word();
        s.gain_i = pick_word();
        s.gain_d = pick_word();
        s.target = pick_word();
        case ($urandom_range(5))
            0:       s.limit = '0;
            1:       s.limit = 31'h7fffffff;
            2:       s.limit = 31'($urandom);
            default: s.limit = 31'($urandom_range(0, 1 << 17));
        endcase
        lo = pick_word();
        hi = pick_word();
        case ($urandom_range(4))
            0: begin
                s.floor_val   = 16'sh8000;
                s.ceiling_val = 16'sh7fff;
            end
            1: begin
                s.floor_val   = lo;
                s.ceiling_val = hi;
            end
            default: begin
                s.floor_val   = (lo < hi) ? lo : hi;
                s.ceiling_val = (lo < hi) ? hi : lo;
            end
        endcase
        load_settings(s);
        mode = $urandom_range(2);
        bias = int'($urandom_range(0, 2000)) - 1000;
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at) rx_hold_left = 80;
            if (k == pause_at) pause_until_drained();
            case (mode)
                0:       meas = pick_word();
                // steady offset from the setpoint drives the integral into its clamp
                1:       meas = DATA_W'(int'($signed(s.target)) + bias
                                        + int'($urandom_range(0, 31)) - 16);
                default: meas = DATA_W'($urandom);
            endcase
            if ($urandom_range(99) < 4) begin
                send_item(OP_CLEAR, DATA_W'($urandom));
            end else begin
                send_item(OP_STEP, meas);
            end
        end
        pause_until_drained();
    endtask

    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.operation   <= OP_STEP;
        item_ch.measurement <= '0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_settings('{gain_p: 256, gain_i: 64, gain_d: -512, target: 100, limit: 3000,
                        floor_val: -32768, ceiling_val: 32767});
        send_item(OP_STEP, 16'h8000);
        send_item(OP_STEP, 16'h7fff);
        send_item(OP_STEP, 16'h0000);
        send_item(OP_STEP, 16'hffff);
        send_item(OP_STEP, 16'd100);
        send_item(OP_CLEAR, 16'h7fff);
        send_item(OP_STEP, 16'd5000);
        repeat (3) send_item(OP_STEP, 16'h8000);
        send_item(OP_CLEAR, 16'h8000);
        send_item(OP_STEP, 16'h5555);
        send_item(OP_STEP, 16'haaaa);
        pause_until_drained();

        // floor above ceiling
        load_settings('{gain_p: 32767, gain_i: 0, gain_d: 0, target: 0, limit: 100,
                        floor_val: 500, ceiling_val: -500});
        send_item(OP_STEP, 16'h8000);
        send_item(OP_STEP, 16'h7fff);
        send_item(OP_STEP, 16'h0000);
        pause_until_drained();

        // extreme gains, zero limit
        load_settings('{gain_p: -32768, gain_i: 32767, gain_d: -32768, target: -32768,
                        limit: 0, floor_val: -32768, ceiling_val: 32767});
        send_item(OP_STEP, 16'h7fff);
        send_item(OP_STEP, 16'h8000);
        send_item(OP_STEP, 16'h7fff);
        send_item(OP_STEP, 16'h0000);
        pause_until_drained();

        // full limit
        load_settings('{gain_p: 0, gain_i: 32767, gain_d: 32767, target: 32767,
                        limit: 31'h7fffffff, floor_val: -32768, ceiling_val: 32767});
        repeat (3) send_item(OP_STEP, 16'h8000);
        send_item(OP_STEP, 16'h7fff);
        pause_until_drained();

        for (int p = 0; p < 12; p++) begin
            tx_idle_pct = (p == 4 || p == 5) ? 0 : 18;
            rx_idle_pct = tx_idle_pct;
            run_random_phase(150, (p == 2) ? 60 : -1, (p == 7) ? 75 : -1);
        end

        repeat (8) @(posedge i_clk);
        if (check_failures == 0) begin
            $display("** pid_controller_antiwindup: PASSED **");
        end else begin
            $display("** pid_controller_antiwindup: FAILED **");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("** pid_controller_antiwindup: FAILED **");
        $finish;
    end

endmodule
